// File: src/nearest_centroid_assigner_unit_defines.svh
// ----------------------------------------------------------------------------
// Nearest centroid assigner: assertion macros
// Shared concurrent assertion helpers, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_ASSIGNER_UNIT_DEFINES_SVH
`define NEAREST_CENTROID_ASSIGNER_UNIT_DEFINES_SVH

// same-cycle implication
`define NCA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/nca_pkg.sv
// ----------------------------------------------------------------------------
// Nearest centroid assigner package
// Sizes, register map and the records passed between lanes and merge.
// ----------------------------------------------------------------------------
package nca_pkg;

    localparam int MAX_CLASSES = 8;
    localparam int MAX_DIM     = 8;
    localparam int MAX_POINTS  = 1024;
    localparam int COORD_BITS  = 16;

    localparam int CLS_W      = $clog2(MAX_CLASSES);
    localparam int CLASS_W    = 3;
    localparam int POINT_W    = 10;
    localparam int DIST_W     = 36;
    localparam int SUM_W      = 48;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int HALF       = (MAX_DIM + 1) / 2;
    localparam int PAIR_W     = SQ_W + 1;
    localparam int TREE_W     = SQ_W + $clog2(MAX_DIM) + 1;
    localparam int CFG_W      = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [63:0] DIST_MAX = (64'd1 << DIST_W) - 64'd1;

    localparam logic [ADDR_W-1:0] REG_CLASS_COUNT = 3'd0;
    localparam logic [ADDR_W-1:0] REG_DIMENSION   = 3'd4;

    localparam logic [CFG_W-1:0] CLASS_COUNT_RST = 4'd2;
    localparam logic [CFG_W-1:0] DIMENSION_RST   = 4'd1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef coord_t [MAX_DIM-1:0] row_t;
    typedef logic [MAX_DIM-1:0][SQ_W-1:0] sq_vec_t;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [CLS_W-1:0] cls;
    } tag_t;

    typedef struct packed {
        logic              done;
        logic [CLS_W-1:0]  cls;
        logic [DIST_W-1:0] sq_dist;
    } res_t;

endpackage

// File: src/nca_lane.sv
// ----------------------------------------------------------------------------
// Nearest centroid assigner: coordinate lane
// Squared difference of one point coordinate and one centroid coordinate,
// registered. A disabled lane contributes zero.
// ----------------------------------------------------------------------------
module nca_lane (
    input  logic                  clk,
    input  logic                  en,
    input  nca_pkg::coord_t       pt,
    input  nca_pkg::coord_t       ce,
    output logic [nca_pkg::SQ_W-1:0] sq
);
    import nca_pkg::*;

    logic signed [COORD_BITS:0] diff;
    logic        [COORD_BITS:0] mag;
    logic        [SQ_W-1:0]     sq_reg;

    always_comb
    begin
        diff = {pt[COORD_BITS-1], pt} - {ce[COORD_BITS-1], ce};
        mag  = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg <= mag[COORD_BITS-1:0] * mag[COORD_BITS-1:0];
        else
            sq_reg <= '0;
    end

    assign sq = sq_reg;

endmodule

// File: src/nca_merge.sv
// ----------------------------------------------------------------------------
// Nearest centroid assigner: merge stage
// Registered adder tree over the lane squares, then a running minimum over
// the centroids of one point, lowest index kept on ties.
// ----------------------------------------------------------------------------
module nca_merge (
    input  logic             clk,
    input  logic             rst_n,
    input  nca_pkg::tag_t    tag_in,
    input  nca_pkg::sq_vec_t sq,
    output nca_pkg::res_t    res
);
    import nca_pkg::*;

    logic [HALF-1:0][PAIR_W-1:0] pair_next;
    logic [HALF-1:0][PAIR_W-1:0] pair_reg;
    logic [TREE_W-1:0]           sum_next;
    logic [TREE_W-1:0]           sum_reg;
    logic [DIST_W-1:0]           dist_b;
    tag_t                        tag_a_reg;
    tag_t                        tag_b_reg;
    logic                        done_reg;
    logic [DIST_W-1:0]           best_dist_reg;
    logic [CLS_W-1:0]            best_cls_reg;

    always_comb
    begin
        for (int i = 0; i < HALF; i++)
        begin
            if (2 * i + 1 < MAX_DIM)
                pair_next[i] = PAIR_W'(sq[2 * i]) + PAIR_W'(sq[2 * i + 1]);
            else
                pair_next[i] = PAIR_W'(sq[2 * i]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < HALF; i++)
            sum_next = sum_next + TREE_W'(pair_reg[i]);
    end

    // saturate to the distance width
    always_comb
    begin
        if (64'(sum_reg) > DIST_MAX)
            dist_b = '1;
        else
            dist_b = DIST_W'(sum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            done_reg  <= tag_b_reg.vld && tag_b_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
        sum_reg  <= sum_next;
        if (tag_b_reg.vld && (tag_b_reg.first || dist_b < best_dist_reg))
        begin
            best_dist_reg <= dist_b;
            best_cls_reg  <= tag_b_reg.cls;
        end
    end

    assign res.done    = done_reg;
    assign res.cls     = best_cls_reg;
    assign res.sq_dist = best_dist_reg;

endmodule

// File: src/nearest_centroid_assigner_unit.sv
// ----------------------------------------------------------------------------
// Nearest centroid assigner
// A point request reads one centroid row per cycle (class_count rows,
// class_count clamped to 1..8), then passes the lanes, two adder stages,
// compare, hand-off and the output register to give its result.
// No new request is taken until the request side reopens in the cycle
// the result is shown, later while the result waits on stall.
// A centroid write request is stored at acceptance and gives no result.
// Reset clears control, sets class_count 2 and dimension 1, and marks every
// table row as zero through its valid bit; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "nearest_centroid_assigner_unit_defines.svh"

module nearest_centroid_assigner_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nca_pkg::ADDR_W-1:0]      paddr,
    input  logic [nca_pkg::DATA_W-1:0]      pwdata,
    output logic [nca_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            kind,
    input  logic [2:0]                      centroid_index,
    input  logic                            first_point,
    input  nca_pkg::coord_t                 coord_0,
    input  nca_pkg::coord_t                 coord_1,
    input  nca_pkg::coord_t                 coord_2,
    input  nca_pkg::coord_t                 coord_3,
    input  nca_pkg::coord_t                 coord_4,
    input  nca_pkg::coord_t                 coord_5,
    input  nca_pkg::coord_t                 coord_6,
    input  nca_pkg::coord_t                 coord_7,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [nca_pkg::CLASS_W-1:0]     nearest_class,
    output logic [nca_pkg::DIST_W-1:0]      min_distance,
    output logic [nca_pkg::POINT_W-1:0]     point_index,
    output logic [nca_pkg::SUM_W-1:0]       inertia_sum,
    output logic [nca_pkg::POINT_W-1:0]     worst_index
);
    import nca_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       class_count_reg;
    logic [CFG_W-1:0]       dimension_reg;
    logic [MAX_CLASSES-1:0] row_vld_reg;
    row_t                   cent_mem [MAX_CLASSES];
    row_t                   rd_row_reg;
    logic                   rd_vld_reg;
    row_t                   cent_row;
    row_t                   point_reg;
    row_t                   req_row;
    coord_t                 req_coords [8];
    logic                   first_reg;
    logic [CLS_W-1:0]       k_reg, k_next;
    logic [CLS_W-1:0]       last_cls;
    tag_t                   tag0_reg, tag0_next;
    tag_t                   tag1_reg;
    logic [MAX_DIM-1:0]     lane_en;
    sq_vec_t                sq;
    res_t                   res_q;
    logic                   req_acc;
    logic                   cfg_wr;
    logic                   row_wr;
    logic                   out_free;
    logic                   out_load;

    logic [POINT_W-1:0]     cnt_reg, base_cnt, cnt_next;
    logic [SUM_W-1:0]       sum_reg, base_sum, sum_next;
    logic [SUM_W:0]         sum_wide;
    logic [DIST_W-1:0]      wd_reg, base_wd, wd_next;
    logic [POINT_W-1:0]     wp_reg, base_wp, wp_next;
    logic                   res_valid_reg;
    logic [CLASS_W-1:0]     class_out_reg;
    logic [DIST_W-1:0]      dist_out_reg;
    logic [POINT_W-1:0]     idx_out_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr)
            REG_CLASS_COUNT: prdata = DATA_W'(class_count_reg);
            REG_DIMENSION:   prdata = DATA_W'(dimension_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= CLASS_COUNT_RST;
            dimension_reg   <= DIMENSION_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                REG_CLASS_COUNT: class_count_reg <= pwdata[CFG_W-1:0];
                REG_DIMENSION:   dimension_reg   <= pwdata[CFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamped limits
    always_comb
    begin
        if (class_count_reg == '0)
            last_cls = '0;
        else if (32'(class_count_reg) > MAX_CLASSES)
            last_cls = CLS_W'(MAX_CLASSES - 1);
        else
            last_cls = CLS_W'(32'(class_count_reg) - 1);
        for (int d = 0; d < MAX_DIM; d++)
            lane_en[d] = (d == 0) || (d < 32'(dimension_reg));
    end

    // request side
    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign row_wr    = req_acc && (kind == KIND_WRITE) && (32'(centroid_index) < MAX_CLASSES);

    always_comb
    begin
        req_coords[0] = coord_0;
        req_coords[1] = coord_1;
        req_coords[2] = coord_2;
        req_coords[3] = coord_3;
        req_coords[4] = coord_4;
        req_coords[5] = coord_5;
        req_coords[6] = coord_6;
        req_coords[7] = coord_7;
        for (int d = 0; d < MAX_DIM; d++)
            req_row[d] = req_coords[d];
    end

    // centroid table
    always_ff @(posedge clk)
    begin
        if (row_wr)
            cent_mem[CLS_W'(centroid_index)] <= req_row;
        rd_row_reg <= cent_mem[k_reg];
        rd_vld_reg <= row_vld_reg[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_vld_reg <= '0;
        else if (row_wr)
            row_vld_reg[CLS_W'(centroid_index)] <= 1'b1;
    end

    assign cent_row = rd_vld_reg ? rd_row_reg : '0;

    // sequencer
    assign out_free = !res_valid_reg || !res_stall;
    assign out_load = (state_reg == ST_HOLD) && out_free;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        tag0_next  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (req_acc && kind == KIND_POINT)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                tag0_next.vld   = 1'b1;
                tag0_next.first = (k_reg == '0);
                tag0_next.last  = (k_reg == last_cls);
                tag0_next.cls   = k_reg;
                if (k_reg == last_cls)
                    state_next = ST_DRAIN;
                else
                    k_next = k_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (res_q.done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            tag0_reg  <= '0;
            tag1_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            tag0_reg  <= tag0_next;
            tag1_reg  <= tag0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc && kind == KIND_POINT)
        begin
            point_reg <= req_row;
            first_reg <= first_point;
        end
    end

    // lanes and merge
    for (genvar d = 0; d < MAX_DIM; d++)
    begin : g_lane
        nca_lane u_lane (
            .clk (clk),
            .en  (lane_en[d]),
            .pt  (point_reg[d]),
            .ce  (cent_row[d]),
            .sq  (sq[d])
        );
    end

    nca_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_in (tag1_reg),
        .sq     (sq),
        .res    (res_q)
    );

    // pass statistics
    always_comb
    begin
        base_cnt = first_reg ? '0 : cnt_reg;
        base_sum = first_reg ? '0 : sum_reg;
        base_wd  = first_reg ? '0 : wd_reg;
        base_wp  = first_reg ? '0 : wp_reg;

        if (32'(base_cnt) >= MAX_POINTS - 1)
            cnt_next = '0;
        else
            cnt_next = base_cnt + 1'b1;

        sum_wide = {1'b0, base_sum} + (SUM_W + 1)'(res_q.sq_dist);
        sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

        if (res_q.sq_dist > base_wd)
        begin
            wd_next = res_q.sq_dist;
            wp_next = base_cnt;
        end
        else
        begin
            wd_next = base_wd;
            wp_next = base_wp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sum_reg       <= '0;
            wd_reg        <= '0;
            wp_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                cnt_reg <= cnt_next;
                sum_reg <= sum_next;
                wd_reg  <= wd_next;
                wp_reg  <= wp_next;
            end
            if (out_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            class_out_reg <= CLASS_W'(res_q.cls);
            dist_out_reg  <= res_q.sq_dist;
            idx_out_reg   <= base_cnt;
        end
    end

    assign res_valid     = res_valid_reg;
    assign nearest_class = class_out_reg;
    assign min_distance  = dist_out_reg;
    assign point_index   = idx_out_reg;
    assign inertia_sum   = sum_reg;
    assign worst_index   = wp_reg;

    `NCA_ASSERT_NOW(a_done_in_drain, clk, rst_n, res_q.done, state_reg == ST_DRAIN, "merge done outside drain")
    `NCA_ASSERT_NEXT(a_load_shows, clk, rst_n, out_load, res_valid_reg, "loaded result not shown")
    `NCA_ASSERT_NOW(a_sum_covers, clk, rst_n, res_valid_reg, inertia_sum >= SUM_W'(min_distance), "pass sum below distance")

endmodule

// File: tb/sv/tb_nearest_centroid_assigner_unit.sv
// ----------------------------------------------------------------------------
// Nearest centroid assigner testbench
// Loads centroid rows and classifies points through the request channel,
// predicts class, distance, pass index, inertia and worst point in step,
// and checks every result in order under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_nearest_centroid_assigner_unit;

    import nca_pkg::*;

    localparam longint unsigned SUM_LIMIT = 64'h0000_FFFF_FFFF_FFFF;
    localparam int              MAX_SHOWN = 40;

    typedef struct {
        logic        kind;
        logic [2:0]  row;
        logic        first;
        row_t        coord;
    } request_t;

    typedef struct {
        logic [CLASS_W-1:0] cls;
        logic [DIST_W-1:0]  sq_dist;
        logic [POINT_W-1:0] idx;
        logic [SUM_W-1:0]   sum;
        logic [POINT_W-1:0] worst;
    } assignment_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic                kind = 1'b0;
    logic [2:0]          centroid_index = '0;
    logic                first_point = 1'b0;
    coord_t              coord_0 = '0;
    coord_t              coord_1 = '0;
    coord_t              coord_2 = '0;
    coord_t              coord_3 = '0;
    coord_t              coord_4 = '0;
    coord_t              coord_5 = '0;
    coord_t              coord_6 = '0;
    coord_t              coord_7 = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [CLASS_W-1:0]  nearest_class;
    logic [DIST_W-1:0]   min_distance;
    logic [POINT_W-1:0]  point_index;
    logic [SUM_W-1:0]    inertia_sum;
    logic [POINT_W-1:0]  worst_index;

    // predicted block state
    row_t                centroid_rows [MAX_CLASSES] = '{default: '0};
    logic [3:0]          cfg_classes = CLASS_COUNT_RST;
    logic [3:0]          cfg_dim = DIMENSION_RST;
    logic [POINT_W-1:0]  pass_count = '0;
    longint unsigned     pass_sum = 0;
    longint unsigned     worst_dist = 0;
    logic [POINT_W-1:0]  worst_point = '0;

    assignment_t         pending_assignments [$];
    assignment_t         oldest;
    bit                  calm = 1'b0;
    int                  mismatches = 0;
    int                  points_sent = 0;
    int                  rows_loaded = 0;
    int                  settings_used = 0;
    int                  results_checked = 0;

    nearest_centroid_assigner_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .kind           (kind),
        .centroid_index (centroid_index),
        .first_point    (first_point),
        .coord_0        (coord_0),
        .coord_1        (coord_1),
        .coord_2        (coord_2),
        .coord_3        (coord_3),
        .coord_4        (coord_4),
        .coord_5        (coord_5),
        .coord_6        (coord_6),
        .coord_7        (coord_7),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .nearest_class  (nearest_class),
        .min_distance   (min_distance),
        .point_index    (point_index),
        .inertia_sum    (inertia_sum),
        .worst_index    (worst_index)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(36_000_000);
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch: %s", msg);
    endtask

    function automatic int clamp_cfg(input logic [3:0] v, input int top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic row_t fill(input coord_t v);
        fill = {MAX_DIM{v}};
    endfunction

    function automatic coord_t jitter(input coord_t base);
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3, 4: return coord_t'($urandom);
            default: return coord_t'(int'(base) + int'($urandom_range(600)) - 300);
        endcase
    endfunction

    function automatic row_t random_row(input row_t base);
        row_t r;
        for (int d = 0; d < MAX_DIM; d++)
            r[d] = jitter(base[d]);
        return r;
    endfunction

    function automatic logic [3:0] pick_setting();
        if ($urandom_range(99) < 15)
            return $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
        return 4'($urandom_range(8, 1));
    endfunction

    // nearest class, distance and pass tracking for one accepted point; a write request updates its row
    task automatic update_clusters(input request_t r);
        assignment_t     a;
        int              classes;
        int              dims;
        longint          diff;
        longint unsigned acc;
        longint unsigned best_d;
        int              best_k;
        if (r.kind == KIND_WRITE)
        begin
            centroid_rows[r.row] = r.coord;
            rows_loaded++;
            return;
        end
        if (r.first)
        begin
            pass_count = '0;
            pass_sum = 0;
            worst_dist = 0;
            worst_point = '0;
        end
        classes = clamp_cfg(cfg_classes, MAX_CLASSES);
        dims = clamp_cfg(cfg_dim, MAX_DIM);
        best_d = 0;
        best_k = 0;
        for (int k = 0; k < classes; k++)
        begin
            acc = 0;
            for (int d = 0; d < dims; d++)
            begin
                diff = longint'($signed(r.coord[d])) - longint'($signed(centroid_rows[k][d]));
                acc += longint'(diff * diff);
                if (acc > DIST_MAX)
                    acc = DIST_MAX;
            end
            if (k == 0 || acc < best_d)
            begin
                best_d = acc;
                best_k = k;
            end
        end
        a.cls = best_k[CLASS_W-1:0];
        a.sq_dist = best_d[DIST_W-1:0];
        a.idx = pass_count;
        pass_count = pass_count + 1'b1;
        if (SUM_LIMIT - pass_sum < best_d)
            pass_sum = SUM_LIMIT;
        else
            pass_sum += best_d;
        if (best_d > worst_dist)
        begin
            worst_dist = best_d;
            worst_point = a.idx;
        end
        a.sum = pass_sum[SUM_W-1:0];
        a.worst = worst_point;
        pending_assignments.push_back(a);
        points_sent++;
    endtask

    task automatic send_request(input request_t r);
        while (!calm && $urandom_range(99) < 12)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid      <= 1'b1;
        kind           <= r.kind;
        centroid_index <= r.row;
        first_point    <= r.first;
        coord_0        <= r.coord[0];
        coord_1        <= r.coord[1];
        coord_2        <= r.coord[2];
        coord_3        <= r.coord[3];
        coord_4        <= r.coord[4];
        coord_5        <= r.coord[5];
        coord_6        <= r.coord[6];
        coord_7        <= r.coord[7];
        @(negedge clk);
        while (req_stall)
            @(negedge clk);
        @(posedge clk);
        update_clusters(r);
    endtask

    task automatic write_row(input logic [2:0] row, input row_t c, input logic first);
        request_t r;
        r.kind = KIND_WRITE;
        r.row = row;
        r.first = first;
        r.coord = c;
        send_request(r);
    endtask

    task automatic classify(input row_t c, input logic first);
        request_t r;
        r.kind = KIND_POINT;
        r.row = 3'($urandom);
        r.first = first;
        r.coord = c;
        send_request(r);
    endtask

    // sender holds off until every result is back and the pipe is empty
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_register(input logic [ADDR_W-1:0] addr, input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {28'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_CLASS_COUNT)
            cfg_classes = value;
        else
            cfg_dim = value;
        settings_used++;
    endtask

    task automatic test_reset_state();
        classify(fill(16'sh1234), 1'b0);
        write_row(3'd1, fill(16'sh1234), 1'b1);
        classify(fill(16'sh1234), 1'b0);
    endtask

    task automatic test_extremes();
        row_t alt;
        for (int d = 0; d < MAX_DIM; d++)
            alt[d] = d[0] ? 16'sh7FFF : 16'sh8000;
        settle();
        set_register(REG_CLASS_COUNT, 4'd8);
        set_register(REG_DIMENSION, 4'd8);
        write_row(3'd0, fill(16'sh8000), 1'b0);
        write_row(3'd1, fill(16'sh7FFF), 1'b1);
        write_row(3'd2, fill(16'sh0000), 1'b0);
        write_row(3'd3, fill(16'shFFFF), 1'b0);
        write_row(3'd4, fill(16'sh0000), 1'b0);
        for (int r = 5; r < MAX_CLASSES; r++)
            write_row(3'(r), random_row(fill(16'sh0000)), 1'b0);
        classify(fill(16'sh7FFF), 1'b1);
        classify(fill(16'sh8000), 1'b0);
        classify(fill(16'sh0000), 1'b0);
        classify(random_row(fill(16'sh1000)), 1'b0);
        classify(alt, 1'b0);
    endtask

    task automatic test_register_clamp();
        settle();
        set_register(REG_CLASS_COUNT, 4'd0);
        set_register(REG_DIMENSION, 4'd15);
        classify(fill(16'sh4000), 1'b0);
        settle();
        set_register(REG_CLASS_COUNT, 4'd15);
        set_register(REG_DIMENSION, 4'd0);
        classify(fill(16'shC000), 1'b0);
        settle();
        set_register(REG_CLASS_COUNT, 4'd9);
        set_register(REG_DIMENSION, 4'd9);
        classify(fill(16'sh2000), 1'b0);
    endtask

    // point sits on the only centroid: worst index stays at its cleared value
    task automatic test_zero_distance();
        settle();
        set_register(REG_CLASS_COUNT, 4'd1);
        set_register(REG_DIMENSION, 4'd8);
        classify(centroid_rows[0], 1'b1);
        classify(centroid_rows[0], 1'b0);
    endtask

    // maximum distance every point: point index wraps within one pass
    task automatic test_long_pass();
        settle();
        set_register(REG_CLASS_COUNT, 4'd1);
        set_register(REG_DIMENSION, 4'd8);
        write_row(3'd0, fill(16'sh8000), 1'b1);
        for (int n = 0; n < 1100; n++)
            classify(fill(16'sh7FFF), n == 0);
    endtask

    task automatic test_random();
        logic [3:0] classes;
        logic [3:0] dims;
        int         sel;
        int         active;
        for (int phase = 0; phase < 12; phase++)
        begin
            settle();
            calm = (phase == 5);
            case (phase)
                0:
                begin
                    classes = 4'd8;
                    dims = 4'd8;
                end
                1:
                begin
                    classes = 4'd1;
                    dims = 4'd1;
                end
                2:
                begin
                    classes = 4'd0;
                    dims = 4'd15;
                end
                3:
                begin
                    classes = 4'd15;
                    dims = 4'd0;
                end
                default:
                begin
                    classes = pick_setting();
                    dims = pick_setting();
                end
            endcase
            set_register(REG_CLASS_COUNT, classes);
            set_register(REG_DIMENSION, dims);
            active = clamp_cfg(classes, MAX_CLASSES);
            for (int r = 0; r < MAX_CLASSES; r++)
                write_row(3'(r), random_row(fill(coord_t'($urandom))), 1'($urandom));
            for (int n = 0; n < 55; n++)
            begin
                sel = $urandom_range(99);
                if (sel < 8)
                begin
                    if ($urandom_range(1))
                        write_row(3'($urandom), centroid_rows[$urandom_range(7)], 1'($urandom));
                    else
                        write_row(3'($urandom), random_row(fill(coord_t'($urandom))),
                                  1'($urandom));
                end
                else if (sel < 15)
                    classify(random_row(fill(coord_t'($urandom))), $urandom_range(99) < 4);
                else
                    classify(random_row(centroid_rows[$urandom_range(active - 1)]),
                             n == 0 || $urandom_range(99) < 4);
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge clk)
        res_stall <= !calm && ($urandom_range(99) < 12);

    always @(negedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_assignments.size() == 0)
                report_mismatch($sformatf("result for point %0d with no point waiting",
                                          point_index));
            else
            begin
                oldest = pending_assignments.pop_front();
                results_checked++;
                if (nearest_class !== oldest.cls)
                    report_mismatch($sformatf("point %0d nearest_class %0d, expected %0d",
                                              oldest.idx, nearest_class, oldest.cls));
                if (min_distance !== oldest.sq_dist)
                    report_mismatch($sformatf("point %0d min_distance %0d, expected %0d",
                                              oldest.idx, min_distance, oldest.sq_dist));
                if (point_index !== oldest.idx)
                    report_mismatch($sformatf("point_index %0d, expected %0d",
                                              point_index, oldest.idx));
                if (inertia_sum !== oldest.sum)
                    report_mismatch($sformatf("point %0d inertia_sum %0d, expected %0d",
                                              oldest.idx, inertia_sum, oldest.sum));
                if (worst_index !== oldest.worst)
                    report_mismatch($sformatf("point %0d worst_index %0d, expected %0d",
                                              oldest.idx, worst_index, oldest.worst));
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_extremes();
        test_register_clamp();
        test_zero_distance();
        test_long_pass();
        test_random();
        settle();
        repeat (10) @(posedge clk);
        $display("Classified %0d points against %0d centroid row loads, %0d register writes",
                 points_sent, rows_loaded, settings_used);
        $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
